### src/dnts_pkg.sv
// Shared constants and codes for the directional nearest target search core.
package dnts_pkg;

	// Command codes carried by a request
	localparam logic [1:0] CMD_APPEND = 2'd0;
	localparam logic [1:0] CMD_SEARCH = 2'd1;
	localparam logic [1:0] CMD_CLEAR  = 2'd2;

	// Search direction codes
	localparam logic [2:0] DIR_LEFT       = 3'd0;
	localparam logic [2:0] DIR_RIGHT      = 3'd1;
	localparam logic [2:0] DIR_TOP        = 3'd2;
	localparam logic [2:0] DIR_BOTTOM     = 3'd3;
	localparam logic [2:0] DIR_BOTTOM_TWO = 3'd4;
	localparam logic [2:0] DIR_TOP_TWO    = 3'd5;

	// Fixed field widths and the row weight of the two-way score
	localparam int CMD_W       = 2;
	localparam int DIR_W       = 3;
	localparam int DIST_W      = 32;
	localparam int FOUND_IDX_W = 6;
	localparam int ROW_WEIGHT  = 1000;

endpackage

### src/dnts_req_if.sv
// Request channel: append, search or clear commands with their payload.
interface dnts_req_if
	import dnts_pkg::*;
#(
	parameter int COORD_BITS = 12
);
	logic                          valid;
	logic                          ready;
	logic [CMD_W-1:0]              command;
	logic signed [COORD_BITS-1:0]  cand_x;
	logic signed [COORD_BITS-1:0]  cand_y;
	logic signed [COORD_BITS-1:0]  query_x;
	logic signed [COORD_BITS-1:0]  query_y;
	logic [DIR_W-1:0]              direction;
	logic signed [DIST_W-1:0]      start_dist;

	modport source (
		output valid, command, cand_x, cand_y, query_x, query_y, direction, start_dist,
		input  ready
	);
	modport sink (
		input  valid, command, cand_x, cand_y, query_x, query_y, direction, start_dist,
		output ready
	);
endinterface

### src/dnts_rsp_if.sv
// Response channel: outcome of one search.
interface dnts_rsp_if
	import dnts_pkg::*;
;
	logic                      valid;
	logic                      ready;
	logic                      found;
	logic [FOUND_IDX_W-1:0]    found_index;
	logic signed [DIST_W-1:0]  best_dist;
	logic                      dropped;

	modport source (
		output valid, found, found_index, best_dist, dropped,
		input  ready
	);
	modport sink (
		input  valid, found, found_index, best_dist, dropped,
		output ready
	);
endinterface

### src/dnts_ram.sv
// Generic single-write, single-read RAM with registered read data.
module dnts_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 64,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                          clk,
	input  logic                          we,
	input  logic [ADDR_W-1:0]             waddr,
	input  logic [WIDTH-1:0]              wdata,
	input  logic [ADDR_W-1:0]             raddr,
	output logic [WIDTH-1:0]              rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end
endmodule

### src/directional_nearest_target_search_core.sv
// Search core: appends and clears are done in the idle state and never leave it.
// A search scores the stored points in a pipeline, one point per cycle; cardinal searches
// that find nothing in the cone make a second pass, and a done state, held while the last
// response waits, hands the response over. No request is taken while a search runs. Reset
// clears the point count, drop flag, sequencer and response valid; the point memory is never
// cleared.
module directional_nearest_target_search_core
	import dnts_pkg::*;
#(
	parameter int MAX_CANDIDATES = 64,
	parameter int COORD_BITS     = 12
) (
	input  logic        clk,
	input  logic        arst_n,
	dnts_req_if.sink    req,
	dnts_rsp_if.source  rsp
);
	localparam int ADDR_W = (MAX_CANDIDATES > 1) ? $clog2(MAX_CANDIDATES) : 1;
	localparam int CNT_W  = $clog2(MAX_CANDIDATES + 1);
	localparam int DW     = COORD_BITS + 1;
	localparam int SQ_W   = 2 * DW + 1;
	localparam int ROW_SW = COORD_BITS + 13;
	localparam int SW     = (SQ_W > ROW_SW) ? SQ_W : ROW_SW;
	localparam logic signed [SW-1:0] ROW_K = SW'(ROW_WEIGHT);

	typedef enum logic [1:0] {ST_IDLE, ST_SWEEP, ST_DONE} state_t;

	state_t state_q;
	logic [CNT_W-1:0]  count_q;
	logic              drop_q;
	logic [CNT_W-1:0]  issue_idx_q;
	logic              pass_q;
	logic              found_q;
	logic              v_s1, v_s2, v_s3;
	logic              rsp_valid_q;

	// Search context and running best
	logic signed [COORD_BITS-1:0] qx_q, qy_q;
	logic [DIR_W-1:0]             dir_q;
	logic signed [DIST_W-1:0]     best_q;
	logic [ADDR_W-1:0]            win_q;

	// Pipeline payload
	logic [ADDR_W-1:0]            idx_s1, idx_s2, idx_s3;
	logic signed [DW-1:0]         dx_s2, dy_s2;
	logic signed [COORD_BITS-1:0] cx_s2;
	logic                         ok_s3;
	logic signed [SW-1:0]         score_s3;

	// Response payload
	logic                         rsp_found_q;
	logic [FOUND_IDX_W-1:0]       rsp_index_q;
	logic signed [DIST_W-1:0]     rsp_dist_q;
	logic                         rsp_drop_q;

	logic                         req_fire, issue_v, pass_end, hit, cardinal, rsp_free;
	logic                         ram_we;
	logic [2*COORD_BITS-1:0]      rdata;
	logic signed [COORD_BITS-1:0] rd_x, rd_y;
	logic signed [DIST_W-1:0]     score_ext;

	// Point memory: y in the upper half, x in the lower half
	assign ram_we = req_fire && (req.command == CMD_APPEND)
		&& (count_q < CNT_W'(MAX_CANDIDATES));

	dnts_ram #(
		.WIDTH (2 * COORD_BITS),
		.DEPTH (MAX_CANDIDATES)
	) u_points (
		.clk   (clk),
		.we    (ram_we),
		.waddr (count_q[ADDR_W-1:0]),
		.wdata ({req.cand_y, req.cand_x}),
		.raddr (issue_idx_q[ADDR_W-1:0]),
		.rdata (rdata)
	);

	assign rd_x = $signed(rdata[COORD_BITS-1:0]);
	assign rd_y = $signed(rdata[2*COORD_BITS-1:COORD_BITS]);

	assign req.ready = (state_q == ST_IDLE);
	assign req_fire  = req.valid && req.ready;
	assign issue_v   = (state_q == ST_SWEEP) && (issue_idx_q < count_q);
	assign pass_end  = (state_q == ST_SWEEP) && !issue_v && !v_s1 && !v_s2 && !v_s3;
	assign cardinal  = (dir_q == DIR_LEFT) || (dir_q == DIR_RIGHT)
		|| (dir_q == DIR_TOP) || (dir_q == DIR_BOTTOM);
	assign rsp_free  = !rsp_valid_q || rsp.ready;

	// Score validity and value for the point in stage two
	logic signed [DW-1:0]    adx, ady;
	logic signed [2*DW-1:0]  dxx, dyy;
	logic signed [SW-1:0]    sq_sum, row_term, cx_ext;
	logic                    cone, ok_c;
	logic signed [SW-1:0]    score_c;

	always_comb begin
		adx      = (dx_s2 < 0) ? -dx_s2 : dx_s2;
		ady      = (dy_s2 < 0) ? -dy_s2 : dy_s2;
		dxx      = dx_s2 * dx_s2;
		dyy      = dy_s2 * dy_s2;
		sq_sum   = SW'(dxx) + SW'(dyy);
		row_term = SW'(dy_s2) * ROW_K;
		cx_ext   = SW'(cx_s2);
		cone     = !pass_q;
		unique case (dir_q)
			DIR_LEFT:       ok_c = (dx_s2 < 0) && (!cone || (adx > ady));
			DIR_RIGHT:      ok_c = (dx_s2 > 0) && (!cone || (adx > ady));
			DIR_TOP:        ok_c = (dy_s2 < 0) && (!cone || (adx < ady));
			DIR_BOTTOM:     ok_c = (dy_s2 > 0) && (!cone || (adx < ady));
			DIR_BOTTOM_TWO: ok_c = (dy_s2 > 0) || ((dy_s2 == 0) && (dx_s2 > 0));
			DIR_TOP_TWO:    ok_c = (dy_s2 < 0) || ((dy_s2 == 0) && (dx_s2 < 0));
			default:        ok_c = 1'b1;
		endcase
		unique case (dir_q)
			DIR_BOTTOM_TWO: score_c = row_term + cx_ext;
			DIR_TOP_TWO:    score_c = -row_term - cx_ext;
			default:        score_c = sq_sum;
		endcase
	end

	// Compare the stage-three score against the running best
	assign score_ext = DIST_W'(score_s3);
	assign hit       = v_s3 && ok_s3 && (score_ext < best_q);

	// Sequencer, pipeline valids and response handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			drop_q      <= 1'b0;
			issue_idx_q <= '0;
			pass_q      <= 1'b0;
			found_q     <= 1'b0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			// load a finished response, else drop the response once taken
			if ((state_q == ST_DONE) && rsp_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			// advance the scoring pipeline
			v_s1 <= issue_v;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			if (issue_v) begin
				issue_idx_q <= issue_idx_q + 1'b1;
			end
			if (hit) begin
				found_q <= 1'b1;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (req_fire) begin
						unique case (req.command)
							CMD_APPEND: begin
								if (count_q < CNT_W'(MAX_CANDIDATES)) begin
									count_q <= count_q + 1'b1;
								end else begin
									drop_q <= 1'b1;
								end
							end
							CMD_CLEAR: begin
								count_q <= '0;
								drop_q  <= 1'b0;
							end
							CMD_SEARCH: begin
								state_q     <= ST_SWEEP;
								issue_idx_q <= '0;
								pass_q      <= 1'b0;
								found_q     <= 1'b0;
							end
							default: ;
						endcase
					end
				end
				ST_SWEEP: begin
					if (pass_end) begin
						if (!found_q && !pass_q && cardinal) begin
							pass_q      <= 1'b1;
							issue_idx_q <= '0;
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_DONE: begin
					if (rsp_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Search context, pipeline payload, running best and response payload
	always_ff @(posedge clk) begin
		if (req_fire && (req.command == CMD_SEARCH)) begin
			qx_q   <= req.query_x;
			qy_q   <= req.query_y;
			dir_q  <= req.direction;
			best_q <= req.start_dist;
			win_q  <= '0;
		end else if (hit) begin
			best_q <= score_ext;
			win_q  <= idx_s3;
		end
		idx_s1   <= issue_idx_q[ADDR_W-1:0];
		idx_s2   <= idx_s1;
		dx_s2    <= DW'(rd_x) - DW'(qx_q);
		dy_s2    <= DW'(rd_y) - DW'(qy_q);
		cx_s2    <= rd_x;
		idx_s3   <= idx_s2;
		ok_s3    <= ok_c;
		score_s3 <= score_c;
		if ((state_q == ST_DONE) && rsp_free) begin
			rsp_found_q <= found_q;
			rsp_index_q <= FOUND_IDX_W'(win_q);
			rsp_dist_q  <= best_q;
			rsp_drop_q  <= drop_q;
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.found       = rsp_found_q;
	assign rsp.found_index = rsp_index_q;
	assign rsp.best_dist   = rsp_dist_q;
	assign rsp.dropped     = rsp_drop_q;
endmodule

### tb/directional_nearest_target_search_core_tb.sv
// Testbench for the directional nearest target search core: directed table, then random requests.
`timescale 1ns / 100ps

module directional_nearest_target_search_core_tb;
	import dnts_pkg::*;

	localparam int COORD_BITS      = 12;
	localparam int MAX_CANDIDATES  = 64;
	localparam int RANDOM_REQUESTS = 1950;
	localparam int HOLD_CYCLES     = 500;
	localparam int DRAIN_CYCLES    = 300;

	localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;
	localparam logic [DIR_W-1:0] DIR_ANY   = 3'd6;
	localparam logic [DIR_W-1:0] DIR_SPARE = 3'd7;

	localparam logic signed [DIST_W-1:0] DIST_MAX = 32'sh7fffffff;
	localparam logic signed [DIST_W-1:0] DIST_MIN = 32'sh80000000;

	typedef logic signed [COORD_BITS-1:0] coord_t;

	typedef struct {
		logic [CMD_W-1:0]         command;
		coord_t                   cand_x;
		coord_t                   cand_y;
		coord_t                   query_x;
		coord_t                   query_y;
		logic [DIR_W-1:0]         direction;
		logic signed [DIST_W-1:0] start_dist;
	} request_t;

	typedef struct {
		logic                     found;
		logic [FOUND_IDX_W-1:0]   found_index;
		logic signed [DIST_W-1:0] best_dist;
		logic                     dropped;
	} answer_t;

	typedef struct {
		request_t rq;
		int       reps;
		bit       typed;
		answer_t  want;
	} row_t;

	logic clk;
	logic arst_n;

	dnts_req_if #(.COORD_BITS(COORD_BITS)) req ();
	dnts_rsp_if rsp ();

	directional_nearest_target_search_core #(
		.MAX_CANDIDATES(MAX_CANDIDATES),
		.COORD_BITS(COORD_BITS)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rsp(rsp)
	);

	// Shadow copy of the point list
	coord_t point_x [MAX_CANDIDATES];
	coord_t point_y [MAX_CANDIDATES];
	int     point_count = 0;
	logic   drop_seen = 1'b0;

	answer_t awaited_answers [$];
	row_t    plan [$];
	int      mismatches = 0;
	int      searches_taken = 0;
	int      send_calm = 0;
	logic    rsp_hold = 1'b0;

	// Generate the clock
	initial clk = 1'b0;
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	task automatic report_mismatch(input string what, input longint got, input longint want);
		mismatches++;
		$display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
	endtask

	// Decide whether a stored point qualifies for the direction, and its score
	function automatic logic rank_point(input coord_t cx, input coord_t cy, input coord_t qx,
			input coord_t qy, input logic [DIR_W-1:0] dir, input logic cone,
			output longint score);
		longint dx;
		longint dy;
		longint diff;
		logic   ok;
		dx = longint'(cx) - longint'(qx);
		dy = longint'(cy) - longint'(qy);
		diff = (dx < 0 ? -dx : dx) - (dy < 0 ? -dy : dy);
		case (dir)
			DIR_LEFT:       ok = dx < 0 && (!cone || diff > 0);
			DIR_RIGHT:      ok = dx > 0 && (!cone || diff > 0);
			DIR_TOP:        ok = dy < 0 && (!cone || diff < 0);
			DIR_BOTTOM:     ok = dy > 0 && (!cone || diff < 0);
			DIR_BOTTOM_TWO: ok = dy > 0 || (dy == 0 && dx > 0);
			DIR_TOP_TWO:    ok = dy < 0 || (dy == 0 && dx < 0);
			default:        ok = 1'b1;
		endcase
		if (dir == DIR_BOTTOM_TWO)
			score = dy * ROW_WEIGHT + longint'(cx);
		else if (dir == DIR_TOP_TWO)
			score = -dy * ROW_WEIGHT - longint'(cx);
		else
			score = dx * dx + dy * dy;
		return ok;
	endfunction

	// Cone pass first for cardinal directions, then the half-plane if nothing won
	function automatic answer_t predict_search(input request_t rq);
		answer_t a;
		longint  best;
		longint  s;
		logic    hit;
		int      pass;
		int      i;
		best = longint'(rq.start_dist);
		hit = 1'b0;
		a.found_index = '0;
		for (pass = 0; pass < 2 && !hit; pass++) begin
			for (i = 0; i < point_count; i++) begin
				if (rank_point(point_x[i], point_y[i], rq.query_x, rq.query_y, rq.direction,
						pass == 0, s) && s < best) begin
					best = s;
					a.found_index = i[FOUND_IDX_W-1:0];
					hit = 1'b1;
				end
			end
		end
		a.found = hit;
		a.best_dist = best[DIST_W-1:0];
		a.dropped = drop_seen;
		return a;
	endfunction

	function automatic request_t random_request();
		request_t rq;
		rq.command = CMD_W'($urandom_range(0, 3));
		rq.cand_x = coord_t'($urandom);
		rq.cand_y = coord_t'($urandom);
		rq.query_x = coord_t'($urandom);
		rq.query_y = coord_t'($urandom);
		rq.direction = DIR_W'($urandom_range(0, 7));
		rq.start_dist = $urandom;
		return rq;
	endfunction

	function automatic request_t make_request(input logic [CMD_W-1:0] cmd, input int cx,
			input int cy, input int qx, input int qy, input logic [DIR_W-1:0] dir,
			input logic signed [DIST_W-1:0] start);
		request_t rq;
		rq.command = cmd;
		rq.cand_x = coord_t'(cx);
		rq.cand_y = coord_t'(cy);
		rq.query_x = coord_t'(qx);
		rq.query_y = coord_t'(qy);
		rq.direction = dir;
		rq.start_dist = start;
		return rq;
	endfunction

	function automatic answer_t make_answer(input logic found, input int index,
			input logic signed [DIST_W-1:0] best_score, input logic dropped);
		answer_t a;
		a.found = found;
		a.found_index = FOUND_IDX_W'(index);
		a.best_dist = best_score;
		a.dropped = dropped;
		return a;
	endfunction

	task automatic add_row(input request_t rq, input int reps, input bit typed,
			input answer_t want);
		row_t r;
		r.rq = rq;
		r.reps = reps;
		r.typed = typed;
		r.want = want;
		plan.push_back(r);
	endtask

	// Coordinate styles: wide, tight cluster, coarse grid with ties, range edges
	function automatic coord_t pick_coord(input int mode, input coord_t center);
		case (mode)
			0: return coord_t'($urandom);
			1: return center + coord_t'($urandom_range(0, 40)) - coord_t'(20);
			2: return center + coord_t'($urandom_range(0, 8) * 4) - coord_t'(16);
			default: begin
				case ($urandom_range(0, 3))
					0: return coord_t'(-2048);
					1: return coord_t'(2047);
					2: return coord_t'(0);
					default: return coord_t'(-1);
				endcase
			end
		endcase
	endfunction

	function automatic logic signed [DIST_W-1:0] pick_start();
		int roll;
		roll = $urandom_range(0, 19);
		if (roll < 11)
			return DIST_MAX;
		else if (roll < 14)
			return $urandom;
		else if (roll < 17)
			return int'($urandom_range(0, 3000)) - 1000;
		else if (roll < 19)
			return int'($urandom_range(0, 2000));
		else
			return DIST_MIN;
	endfunction

	// Drive one request, wait for acceptance, update the shadow list, then maybe pause
	task automatic issue_request(input request_t rq, input bit typed, input answer_t want);
		int gap;
		int roll;
		@(negedge clk);
		req.valid <= 1'b1;
		req.command <= rq.command;
		req.cand_x <= rq.cand_x;
		req.cand_y <= rq.cand_y;
		req.query_x <= rq.query_x;
		req.query_y <= rq.query_y;
		req.direction <= rq.direction;
		req.start_dist <= rq.start_dist;
		do @(posedge clk); while (req.ready !== 1'b1);
		case (rq.command)
			CMD_APPEND: begin
				if (point_count < MAX_CANDIDATES) begin
					point_x[point_count] = rq.cand_x;
					point_y[point_count] = rq.cand_y;
					point_count++;
				end else begin
					drop_seen = 1'b1;
				end
			end
			CMD_CLEAR: begin
				point_count = 0;
				drop_seen = 1'b0;
			end
			CMD_SEARCH: begin
				awaited_answers.push_back(typed ? want : predict_search(rq));
				searches_taken++;
			end
			default: ;
		endcase
		// Mostly back to back, some short gaps, a few long ones, and calm stretches
		gap = 0;
		if (send_calm > 0) begin
			send_calm--;
		end else begin
			roll = $urandom_range(0, 99);
			if (roll == 0)
				send_calm = $urandom_range(50, 150);
			else if (roll < 25)
				gap = $urandom_range(1, 3);
			else if (roll < 29)
				gap = $urandom_range(8, 40);
		end
		if (gap > 0) begin
			@(negedge clk);
			req.valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	// Response ready: random stalls, calm stretches, and the long hold-off
	initial begin
		int stall_left;
		int calm_left;
		int roll;
		stall_left = 0;
		calm_left = 0;
		rsp.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_left > 0 || rsp_hold) begin
				rsp.ready <= 1'b0;
				if (stall_left > 0)
					stall_left--;
			end else begin
				rsp.ready <= 1'b1;
				if (calm_left > 0) begin
					calm_left--;
				end else begin
					roll = $urandom_range(0, 99);
					if (roll == 0)
						calm_left = $urandom_range(100, 400);
					else if (roll < 21)
						stall_left = $urandom_range(1, 3);
					else if (roll < 24)
						stall_left = $urandom_range(10, 40);
				end
			end
		end
	end

	// Hold off responses once for a long stretch so the core backs up into the request side
	initial begin
		wait (searches_taken >= 120);
		@(posedge clk);
		rsp_hold = 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		rsp_hold = 1'b0;
	end

	// Check each accepted response against the oldest awaited answer
	always @(posedge clk) begin
		answer_t want;
		if (arst_n && rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
			if (awaited_answers.size() == 0) begin
				report_mismatch("response with no search pending", 0, 0);
			end else begin
				want = awaited_answers.pop_front();
				if (rsp.found !== want.found)
					report_mismatch("found", rsp.found, want.found);
				if (rsp.found_index !== want.found_index)
					report_mismatch("found_index", rsp.found_index, want.found_index);
				if (rsp.best_dist !== want.best_dist)
					report_mismatch("best_dist", longint'(rsp.best_dist),
						longint'(want.best_dist));
				if (rsp.dropped !== want.dropped)
					report_mismatch("dropped", rsp.dropped, want.dropped);
			end
		end
	end

	// Stimulus
	initial begin
		request_t rq;
		request_t step;
		answer_t  none;
		row_t     r;
		coord_t   center_x;
		coord_t   center_y;
		int       random_count;
		int       mode;
		int       fill;
		int       searches;
		int       roll;
		int       j;
		int       k;

		arst_n = 1'b0;
		req.valid = 1'b0;
		req.command = CMD_APPEND;
		req.cand_x = '0;
		req.cand_y = '0;
		req.query_x = '0;
		req.query_y = '0;
		req.direction = DIR_LEFT;
		req.start_dist = '0;
		none = make_answer(1'b0, 0, '0, 1'b0);

		// Directed table: empty list, range extremes, every direction, full list, clear
		add_row(make_request(CMD_SEARCH, 0, 0, 0, 0, DIR_ANY, DIST_MAX), 1, 1'b1,
			make_answer(1'b0, 0, DIST_MAX, 1'b0));
		add_row(make_request(CMD_SEARCH, 0, 0, -2048, 2047, DIR_LEFT, DIST_MIN), 1, 1'b1,
			make_answer(1'b0, 0, DIST_MIN, 1'b0));
		add_row(make_request(CMD_APPEND, -2048, -2048, 0, 0, DIR_LEFT, 0), 1, 1'b0, none);
		add_row(make_request(CMD_APPEND, 2047, 2047, 0, 0, DIR_LEFT, 0), 1, 1'b0, none);
		add_row(make_request(CMD_APPEND, 0, 0, 0, 0, DIR_LEFT, 0), 1, 1'b0, none);
		add_row(make_request(CMD_APPEND, -7, 3, 0, 0, DIR_LEFT, 0), 1, 1'b0, none);
		add_row(make_request(CMD_APPEND, 4, -9, 0, 0, DIR_LEFT, 0), 1, 1'b0, none);
		add_row(make_request(CMD_APPEND, 3, 3, 0, 0, DIR_LEFT, 0), 1, 1'b0, none);
		add_row(make_request(CMD_SEARCH, 0, 0, 0, 0, DIR_LEFT, DIST_MAX), 1, 1'b0, none);
		add_row(make_request(CMD_SEARCH, 0, 0, 0, 0, DIR_RIGHT, DIST_MAX), 1, 1'b0, none);
		add_row(make_request(CMD_SEARCH, 0, 0, 0, 0, DIR_TOP, DIST_MAX), 1, 1'b0, none);
		add_row(make_request(CMD_SEARCH, 0, 0, 0, 0, DIR_BOTTOM, DIST_MAX), 1, 1'b0, none);
		add_row(make_request(CMD_SEARCH, 0, 0, 0, 0, DIR_BOTTOM_TWO, DIST_MAX), 1, 1'b0,
			none);
		add_row(make_request(CMD_SEARCH, 0, 0, 0, 0, DIR_TOP_TWO, DIST_MAX), 1, 1'b0, none);
		add_row(make_request(CMD_SEARCH, 0, 0, 1, -1, DIR_ANY, DIST_MAX), 1, 1'b0, none);
		add_row(make_request(CMD_SEARCH, 0, 0, -1, 1, DIR_SPARE, DIST_MAX), 1, 1'b0, none);
		// A point sitting on the query scores zero and cannot beat a zero start
		add_row(make_request(CMD_SEARCH, 0, 0, 0, 0, DIR_ANY, 0), 1, 1'b1,
			make_answer(1'b0, 0, 0, 1'b0));
		add_row(make_request(CMD_SPARE, 5, 5, 5, 5, DIR_ANY, 0), 1, 1'b0, none);
		add_row(make_request(CMD_SEARCH, 0, 0, 2047, 2047, DIR_LEFT, DIST_MAX), 1, 1'b0,
			none);
		add_row(make_request(CMD_SEARCH, 0, 0, -2048, 0, DIR_RIGHT, -1), 1, 1'b1,
			make_answer(1'b0, 0, -1, 1'b0));
		// Overfill the list so the last appends are dropped
		add_row(make_request(CMD_APPEND, 100, -100, 0, 0, DIR_LEFT, 0), 60, 1'b0, none);
		add_row(make_request(CMD_SEARCH, 0, 0, 0, 0, DIR_ANY, DIST_MAX), 1, 1'b0, none);
		add_row(make_request(CMD_SEARCH, 0, 0, -2048, -2048, DIR_BOTTOM_TWO, DIST_MAX), 1,
			1'b0, none);
		add_row(make_request(CMD_CLEAR, 0, 0, 0, 0, DIR_LEFT, 0), 1, 1'b0, none);
		add_row(make_request(CMD_SEARCH, 0, 0, 0, 0, DIR_ANY, DIST_MAX), 1, 1'b1,
			make_answer(1'b0, 0, DIST_MAX, 1'b0));
		add_row(make_request(CMD_APPEND, 0, 0, 0, 0, DIR_LEFT, 0), 1, 1'b0, none);
		add_row(make_request(CMD_SEARCH, 0, 0, 0, 0, DIR_ANY, 1), 1, 1'b1,
			make_answer(1'b1, 0, 0, 1'b0));

		// Release reset
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Walk the table
		for (j = 0; j < plan.size(); j++) begin
			r = plan[j];
			for (k = 0; k < r.reps; k++) begin
				step = r.rq;
				step.cand_x = r.rq.cand_x + coord_t'(k * 37);
				step.cand_y = r.rq.cand_y - coord_t'(k * 53);
				issue_request(step, r.typed, r.want);
			end
		end

		// Random episodes: clear, load a list in one coordinate style, then search it
		random_count = 0;
		while (random_count < RANDOM_REQUESTS) begin
			mode = $urandom_range(0, 3);
			center_x = coord_t'($urandom);
			center_y = coord_t'($urandom);
			if ($urandom_range(0, 9) != 0) begin
				rq = random_request();
				rq.command = CMD_CLEAR;
				issue_request(rq, 1'b0, none);
				random_count++;
			end
			roll = $urandom_range(0, 9);
			if (roll < 7)
				fill = $urandom_range(0, 20);
			else if (roll < 9)
				fill = $urandom_range(21, 63);
			else
				fill = $urandom_range(64, 72);
			for (k = 0; k < fill; k++) begin
				rq = random_request();
				rq.command = CMD_APPEND;
				rq.cand_x = pick_coord(mode, center_x);
				rq.cand_y = pick_coord(mode, center_y);
				issue_request(rq, 1'b0, none);
				random_count++;
				// Sprinkle in the unused command code
				if ($urandom_range(0, 19) == 0) begin
					rq = random_request();
					rq.command = CMD_SPARE;
					issue_request(rq, 1'b0, none);
				end
			end
			searches = $urandom_range(1, 8);
			for (k = 0; k < searches; k++) begin
				rq = random_request();
				rq.command = CMD_SEARCH;
				roll = $urandom_range(0, 3);
				if (roll == 0 && point_count > 0) begin
					j = $urandom_range(0, point_count - 1);
					rq.query_x = point_x[j];
					rq.query_y = point_y[j];
				end else if (roll < 3) begin
					rq.query_x = pick_coord(mode == 0 ? 1 : mode, center_x);
					rq.query_y = pick_coord(mode == 0 ? 1 : mode, center_y);
				end
				rq.start_dist = pick_start();
				issue_request(rq, 1'b0, none);
				random_count++;
				// Occasionally grow the list between searches
				if ($urandom_range(0, 5) == 0) begin
					rq = random_request();
					rq.command = CMD_APPEND;
					rq.cand_x = pick_coord(mode, center_x);
					rq.cand_y = pick_coord(mode, center_y);
					issue_request(rq, 1'b0, none);
					random_count++;
				end
			end
		end

		// Drain
		@(negedge clk);
		req.valid <= 1'b0;
		while (awaited_answers.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// Give up if the run hangs
	initial begin
		#10_000_000;
		$display("simulation failed");
		$finish;
	end

endmodule

### filelist.f
src/dnts_pkg.sv
src/dnts_req_if.sv
src/dnts_rsp_if.sv
src/dnts_ram.sv
src/directional_nearest_target_search_core.sv
tb/directional_nearest_target_search_core_tb.sv
